// ===== sv/envagc_pkg.sv =====
// shared constants, register codes, controller states and command/status types
package envagc_pkg;

  // sample and fixed point formats
  localparam int SAMPLE_BITS   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int COEF_BITS     = 16;
  localparam int COEF_W        = COEF_BITS + 1;
  localparam int PROD_BITS     = SAMPLE_BITS + COEF_W;

  // coefficient value of 1.0
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_BITS;

  // register reset values
  localparam longint SCALE_RESET_INT = 512;
  localparam logic [SAMPLE_BITS-1:0] INIT_SCALE_RST =
    SAMPLE_BITS'(SCALE_RESET_INT << FRACTION_BITS);
  localparam logic [COEF_W-1:0] ALPHA_RST = COEF_W'(3277);
  localparam logic [COEF_W-1:0] DECAY_RST = COEF_W'(65470);

  // divider: one quotient bit a cycle
  localparam int DIV_STEPS = COEF_BITS + 1;
  localparam int CNT_BITS  = $clog2(DIV_STEPS);

  // stream widths
  localparam int IN_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_RAW  = COEF_W + SAMPLE_BITS;
  localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

  // configuration port
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DIODE_MODE    = 4'd0,
    REG_SMOOTH_ALPHA  = 4'd1,
    REG_SCALE_DECAY   = 4'd2,
    REG_INITIAL_SCALE = 4'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECAY,
    S_SCALE,
    S_LEVEL,
    S_RAISE,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mul_decay;
    logic mul_alpha;
    logic scale_wb;
    logic level_wb;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ===== sv/envagc_ctrl.sv =====
// controller state machine sequencing one item through the datapath
module envagc_ctrl
  import envagc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECAY;
        end
      end
      S_DECAY: begin
        cmd.mul_decay = 1'b1;
        state_next    = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale_wb  = 1'b1;
        cmd.mul_alpha = 1'b1;
        state_next    = S_LEVEL;
      end
      S_LEVEL: begin
        cmd.level_wb = 1'b1;
        state_next   = S_RAISE;
      end
      S_RAISE: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/envagc_dp.sv =====
// datapath: config registers, shared multiplier, level/scale update, divider, output register
module envagc_dp
  import envagc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic [SAMPLE_BITS-1:0]    sample,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COEF_W-1:0]         out_norm,
  output logic [SAMPLE_BITS-1:0]    out_level
);

  // configuration and state
  logic                   diode_mode;
  logic [COEF_W-1:0]      smoothing_alpha;
  logic [COEF_W-1:0]      scale_decay;
  logic [SAMPLE_BITS-1:0] level;
  logic [SAMPLE_BITS-1:0] scale;

  // per item working registers
  logic [SAMPLE_BITS-1:0] x;
  logic [SAMPLE_BITS-1:0] diff;
  logic                   rise;
  logic                   take;
  logic [PROD_BITS-1:0]   prod;
  logic [SAMPLE_BITS:0]   rem;
  logic [COEF_W-1:0]      quo;
  logic [CNT_BITS-1:0]    cnt;
  logic                   scale_zero;

  logic [COEF_W-1:0]      alpha_sat;
  logic [COEF_W-1:0]      decay_sat;
  logic [SAMPLE_BITS-1:0] mul_a;
  logic [COEF_W-1:0]      mul_b;
  logic [SAMPLE_BITS-1:0] prod_hi;
  logic                   prod_frac;
  logic [SAMPLE_BITS-1:0] level_new;
  logic [SAMPLE_BITS-1:0] scale_new;
  logic [SAMPLE_BITS+1:0] trial;
  logic                   q_bit;
  logic [SAMPLE_BITS:0]   rem_sel;

  // coefficients above one saturate to one
  assign alpha_sat = smoothing_alpha[COEF_BITS] ? COEF_ONE : smoothing_alpha;
  assign decay_sat = scale_decay[COEF_BITS] ? COEF_ONE : scale_decay;

  // shared multiplier operand select
  assign mul_a = cmd.mul_alpha ? diff : scale;
  assign mul_b = cmd.mul_alpha ? alpha_sat : decay_sat;

  // floor and fraction flag of the scaled product
  assign prod_hi   = prod[COEF_BITS +: SAMPLE_BITS];
  assign prod_frac = |prod[COEF_BITS-1:0];

  // low-pass step or instant rise
  always_comb begin
    priority if (take) begin
      level_new = x;
    end else if (rise) begin
      level_new = level + prod_hi;
    end else begin
      level_new = level - prod_hi - SAMPLE_BITS'(prod_frac);
    end
  end

  // scale follows the level upward
  assign scale_new = (level > scale) ? level : scale;

  // one restoring divider step
  assign trial   = {1'b0, rem} - {2'b00, scale};
  assign q_bit   = ~trial[SAMPLE_BITS+1];
  assign rem_sel = q_bit ? trial[SAMPLE_BITS:0] : rem;

  assign status.div_last = (cnt == CNT_BITS'(DIV_STEPS - 1));
  assign status.out_free = ~out_valid | out_ready;

  // configuration registers, level and scale
  always_ff @(posedge clk) begin
    if (rst) begin
      diode_mode      <= 1'b1;
      smoothing_alpha <= ALPHA_RST;
      scale_decay     <= DECAY_RST;
      level           <= '0;
      scale           <= INIT_SCALE_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DIODE_MODE:   diode_mode      <= cfg_data[0];
          REG_SMOOTH_ALPHA: smoothing_alpha <= cfg_data[COEF_W-1:0];
          REG_SCALE_DECAY:  scale_decay     <= cfg_data[COEF_W-1:0];
          REG_INITIAL_SCALE: begin
            scale <= cfg_data[SAMPLE_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.scale_wb) begin
        scale <= prod_hi;
      end
      if (cmd.level_wb) begin
        level <= level_new;
      end
      if (cmd.div_init) begin
        scale <= scale_new;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x <= sample;
    end
    if (cmd.mul_decay) begin
      rise <= (x >= level);
      take <= diode_mode & (x > level);
      diff <= (x >= level) ? (x - level) : (level - x);
    end
    if (cmd.mul_decay || cmd.mul_alpha) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.div_init) begin
      rem        <= {1'b0, level};
      quo        <= '0;
      cnt        <= '0;
      scale_zero <= (scale_new == '0);
    end
    if (cmd.div_step) begin
      rem <= {rem_sel[SAMPLE_BITS-1:0], 1'b0};
      quo <= {quo[COEF_W-2:0], q_bit};
      cnt <= cnt + CNT_BITS'(1);
    end
    if (cmd.out_load) begin
      out_norm  <= scale_zero ? '0 : quo;
      out_level <= level;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // partial remainder stays below twice the scale
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && !scale_zero) |-> (rem < {scale, 1'b0}))
    else $error("divider remainder out of range");

  // ratio never exceeds one
  a_ratio_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && !scale_zero) |-> (quo <= COEF_ONE))
    else $error("ratio above one");

  // new level lies between old level and the sample
  a_level_between: assert property (@(posedge clk) disable iff (rst)
    cmd.level_wb |=> (((level >= $past(level)) && (level <= $past(x))) ||
                      ((level <= $past(level)) && (level >= $past(x)))))
    else $error("level left its bounds");

endmodule

// ===== sv/envelope_lpf_agc_normalizer.sv =====
// top level: envelope follower with gain control, controller plus datapath
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_tvalid / s_tready          s_tdata[31:0] sample
//  m_axis    out        m_tvalid / m_tready          m_tdata[16:0] normalized, [48:17] level
//  cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// an item goes through the decay, scale, level, raise, divide and done states from acceptance
// until its result is loaded and the controller is idle again, and no new item is accepted
// before then; the 17-step restoring divider produces one quotient bit a cycle.
// the result sits in an output register; the next item is accepted while it waits,
// and the controller holds in its last state only if that register is still full.
// rst is synchronous: level 0, scale 512.0, registers to their defaults.
// cfg_ready is always high; writes are meant for idle periods only.
module envelope_lpf_agc_normalizer
  import envagc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_BITS-1:0]        s_tdata,   // [31:0] sample
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_BITS-1:0]       m_tdata,   // [16:0] normalized, [48:17] level
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cmd_t                   cmd;
  status_t                status;
  logic [COEF_W-1:0]      out_norm;
  logic [SAMPLE_BITS-1:0] out_level;

  assign cfg_ready = 1'b1;

  // controller
  envagc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  envagc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (s_tdata[SAMPLE_BITS-1:0]),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_norm  (out_norm),
    .out_level (out_level)
  );

  // result packing, zero filled to whole bytes
  assign m_tdata = {{(OUT_BITS - OUT_RAW){1'b0}}, out_level, out_norm};

endmodule

// ===== verif/envelope_lpf_agc_normalizer_tb.sv =====
// self-checking testbench for the envelope follower with gain control
module envelope_lpf_agc_normalizer_tb;
  import envagc_pkg::*;

  localparam int RUN_LIMIT        = 1_500_000;
  localparam int PHASES           = 8;
  localparam int PHASE_ITEMS      = 225;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PRINT_CAP        = 50;
  localparam int PLAN_ROWS        = 31;

  // indexes past the register map, writes there must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_FIRST = CFG_INDEX_BITS'(REG_INITIAL_SCALE + 1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LAST  = '1;

  typedef struct packed {
    logic [COEF_W-1:0]      norm;
    logic [SAMPLE_BITS-1:0] level;
  } env_result_t;

  typedef enum logic [1:0] {
    ROW_WRITE,   // register write
    ROW_SAMPLE,  // sample, result from the predictor
    ROW_KNOWN    // sample, result typed in
  } row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] reg_sel;   // unused on sample rows
    logic [31:0]               value;     // register data or sample
    logic [COEF_W-1:0]         want_norm;
    logic [SAMPLE_BITS-1:0]    want_level;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_BITS-1:0]        s_tdata = '0;     // [31:0] sample
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_BITS-1:0]       m_tdata;          // [16:0] normalized, [48:17] level
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // predictor copy of registers and state
  logic                      model_diode = 1'b1;
  logic [COEF_W-1:0]         model_alpha = 17'd3277;
  logic [COEF_W-1:0]         model_decay = 17'd65470;
  logic [SAMPLE_BITS-1:0]    model_level = '0;
  logic [SAMPLE_BITS-1:0]    model_scale = 32'd512 << 16;

  env_result_t pending_results [$];
  int          mismatch_count = 0;
  bit          quiet = 1'b0;
  bit          long_hold_go = 1'b0;
  bit          long_hold_taken = 1'b0;

  // directed rows: extremes, both filter modes, saturation, spare indexes, zero scale
  row_t plan [PLAN_ROWS] = '{
    '{ROW_KNOWN,  '0,                 32'h0000_0000, 17'd0,     32'd0},
    '{ROW_KNOWN,  '0,                 32'hFFFF_FFFF, 17'd65536, 32'hFFFF_FFFF},
    '{ROW_SAMPLE, '0,                 32'h0001_0000, 17'd0,     32'd0},
    '{ROW_WRITE,  REG_DIODE_MODE,     32'd0,         17'd0,     32'd0},
    '{ROW_WRITE,  REG_SMOOTH_ALPHA,   32'd65536,     17'd0,     32'd0},
    '{ROW_KNOWN,  '0,                 32'h0000_0000, 17'd0,     32'd0},
    '{ROW_WRITE,  REG_SMOOTH_ALPHA,   32'h0001_FFFF, 17'd0,     32'd0},
    '{ROW_SAMPLE, '0,                 32'h1234_5678, 17'd0,     32'd0},
    '{ROW_WRITE,  REG_SMOOTH_ALPHA,   32'd0,         17'd0,     32'd0},
    '{ROW_SAMPLE, '0,                 32'hFFFF_FFFF, 17'd0,     32'd0},
    '{ROW_WRITE,  REG_SCALE_DECAY,    32'h0001_FFFF, 17'd0,     32'd0},
    '{ROW_SAMPLE, '0,                 32'h0000_0000, 17'd0,     32'd0},
    '{ROW_WRITE,  REG_SCALE_DECAY,    32'd0,         17'd0,     32'd0},
    '{ROW_SAMPLE, '0,                 32'h0000_FFFF, 17'd0,     32'd0},
    '{ROW_WRITE,  REG_SPARE_FIRST,    32'hFFFF_FFFF, 17'd0,     32'd0},
    '{ROW_WRITE,  REG_SPARE_LAST,     32'd0,         17'd0,     32'd0},
    '{ROW_SAMPLE, '0,                 32'h0000_0001, 17'd0,     32'd0},
    '{ROW_WRITE,  REG_SMOOTH_ALPHA,   32'd65536,     17'd0,     32'd0},
    '{ROW_KNOWN,  '0,                 32'h0000_0000, 17'd0,     32'd0},
    '{ROW_WRITE,  REG_INITIAL_SCALE,  32'd0,         17'd0,     32'd0},
    '{ROW_WRITE,  REG_SCALE_DECAY,    32'd65536,     17'd0,     32'd0},
    '{ROW_KNOWN,  '0,                 32'h0000_0000, 17'd0,     32'd0},
    '{ROW_KNOWN,  '0,                 32'h0000_0005, 17'd65536, 32'd5},
    '{ROW_WRITE,  REG_INITIAL_SCALE,  32'hFFFF_FFFF, 17'd0,     32'd0},
    '{ROW_WRITE,  REG_DIODE_MODE,     32'd1,         17'd0,     32'd0},
    '{ROW_KNOWN,  '0,                 32'hFFFF_FFFF, 17'd65536, 32'hFFFF_FFFF},
    '{ROW_SAMPLE, '0,                 32'h8000_0000, 17'd0,     32'd0},
    '{ROW_WRITE,  REG_SMOOTH_ALPHA,   32'd1,         17'd0,     32'd0},
    '{ROW_WRITE,  REG_SCALE_DECAY,    32'd65535,     17'd0,     32'd0},
    '{ROW_SAMPLE, '0,                 32'h7FFF_FFFF, 17'd0,     32'd0},
    '{ROW_SAMPLE, '0,                 32'h0000_0000, 17'd0,     32'd0}
  };

  envelope_lpf_agc_normalizer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // coefficients above 1.0 act as 1.0
  function automatic logic [COEF_W-1:0] clamp_coef(input logic [COEF_W-1:0] c);
    return (c > 17'd65536) ? 17'd65536 : c;
  endfunction

  // a * c / 2^16, rounded down or up
  function automatic logic [SAMPLE_BITS-1:0] coef_mul(input logic [SAMPLE_BITS-1:0] a,
                                                      input logic [COEF_W-1:0] c,
                                                      input bit round_up);
    logic [48:0] p;
    p = 49'(a) * 49'(c);
    if (round_up) p = p + 49'h0FFFF;
    return p[47:16];
  endfunction

  // one filter step: decay scale, follow level, raise scale, divide
  function automatic void envelope_step(input logic [SAMPLE_BITS-1:0] x,
                                        output logic [COEF_W-1:0] norm,
                                        output logic [SAMPLE_BITS-1:0] lvl);
    logic [COEF_W-1:0] a;
    logic [47:0]       q;
    a = clamp_coef(model_alpha);
    model_scale = coef_mul(model_scale, clamp_coef(model_decay), 1'b0);
    if (model_diode && x > model_level)
      model_level = x;
    else if (x >= model_level)
      model_level = model_level + coef_mul(x - model_level, a, 1'b0);
    else
      model_level = model_level - coef_mul(model_level - x, a, 1'b1);
    if (model_level > model_scale) model_scale = model_level;
    q = (model_scale != 0) ? {model_level, 16'h0000} / 48'(model_scale) : '0;
    norm = q[COEF_W-1:0];
    lvl  = model_level;
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // stop offering items and wait until every result is back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DIODE_MODE:    model_diode = val[0];
      REG_SMOOTH_ALPHA:  model_alpha = val[COEF_W-1:0];
      REG_SCALE_DECAY:   model_decay = val[COEF_W-1:0];
      REG_INITIAL_SCALE: begin
        model_scale = val;
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [31:0] x, input bit known,
                             input logic [COEF_W-1:0] k_norm,
                             input logic [SAMPLE_BITS-1:0] k_level);
    env_result_t r;
    int          gap;
    s_tvalid <= 1'b1;
    s_tdata  <= IN_BITS'(x);
    do @(posedge clk); while (!s_tready);
    envelope_step(x, r.norm, r.level);
    if (known) begin
      r.norm  = k_norm;
      r.level = k_level;
    end
    pending_results.push_back(r);
    // random sender gap
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: random stalls plus one long hold-off
  initial begin : result_sink
    int n;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_go && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin : result_check
    env_result_t want;
    logic [COEF_W-1:0]      got_norm;
    logic [SAMPLE_BITS-1:0] got_level;
    if (!rst && m_tvalid && m_tready) begin
      got_norm  = m_tdata[16:0];
      got_level = m_tdata[48:17];
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with none pending, norm %0d level %0h",
                                got_norm, got_level));
      end else begin
        want = pending_results.pop_front();
        if (got_norm !== want.norm)
          note_mismatch($sformatf("normalized got %0d want %0d", got_norm, want.norm));
        if (got_level !== want.level)
          note_mismatch($sformatf("level got %0h want %0h", got_level, want.level));
      end
    end
  end

  initial begin : stimulus
    logic [31:0] x;
    logic [31:0] val;
    int          p;
    int          k;
    x = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    for (int r = 0; r < PLAN_ROWS; r++) begin
      case (plan[r].kind)
        ROW_WRITE:  write_reg(plan[r].reg_sel, plan[r].value);
        ROW_SAMPLE: send_sample(plan[r].value, 1'b0, '0, '0);
        default:    send_sample(plan[r].value, 1'b1, plan[r].want_norm, plan[r].want_level);
      endcase
    end

    // random phases, each with its own register setting
    for (p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) quiet <= 1'b1;
      write_reg(CFG_INDEX_BITS'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
      write_reg(REG_DIODE_MODE, (p == 0) ? 32'd0 : (p == 1) ? 32'd1 : $urandom);

      case (p)
        0: val = 32'd1;
        1: val = 32'd65536;
        2: val = 32'h0001_FFFF;
        default:
          case ($urandom_range(0, 3))
            0:       val = $urandom;
            1:       val = $urandom_range(0, 65536);
            default: val = $urandom_range(1, 8000);
          endcase
      endcase
      write_reg(REG_SMOOTH_ALPHA, val);

      case (p)
        0: val = 32'd0;
        1: val = 32'd65536;
        2: val = 32'h0001_FFFF;
        default:
          case ($urandom_range(0, 3))
            0:       val = $urandom;
            1:       val = $urandom_range(0, 65536);
            default: val = $urandom_range(64000, 65536);
          endcase
      endcase
      write_reg(REG_SCALE_DECAY, val);

      case (p)
        0: val = 32'd0;
        1: val = 32'hFFFF_FFFF;
        default: val = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0100_0000);
      endcase
      write_reg(REG_INITIAL_SCALE, val);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        // back up the block against a stalled receiver
        if (p == 3 && k == 40) long_hold_go <= 1'b1;
        // let the pipeline run dry mid-stream
        if (p == 5 && k == 100) wait_idle();
        case ($urandom_range(0, 7))
          0: x = $urandom;
          1: x = $urandom_range(0, 32'h0010_0000);
          2: x = '0;
          3: x = 32'hFFFF_FFFF;
          4, 5: x = x + $urandom_range(0, 4095) - 32'd2048;
          default: x = $urandom >> $urandom_range(0, 31);
        endcase
        send_sample(x, 1'b0, '0, '0);
      end
    end

    // drain and let any stray result show up
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) note_mismatch("predicted results never arrived");
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule
